/* design/x86_16_mov_decoder_assert.svh */
// Assertion macros shared by the MOV decoder modules.
`ifndef X86_16_MOV_DECODER_ASSERT_SVH
`define X86_16_MOV_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define XMD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define XMD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/xmd_pkg.sv */
// Types, codes and constants of the 8086 MOV decoder.
`default_nettype none

package xmd_pkg;

    localparam int XMD_QUEUE_DEPTH = 2;

    // Opcode patterns of the two recognized MOV encodings.
    localparam logic [5:0] MOV_RM_OP  = 6'b100010;
    localparam logic [3:0] MOV_IMM_OP = 4'b1011;
    localparam logic [2:0] RM_DIRECT  = 3'b110;

    localparam logic [1:0] MOD_NO_DISP = 2'b00;
    localparam logic [1:0] MOD_DISP8   = 2'b01;
    localparam logic [1:0] MOD_DISP16  = 2'b10;
    localparam logic [1:0] MOD_REG     = 2'b11;

    // Result form codes.
    localparam logic [2:0] FORM_REG_REG = 3'd0;
    localparam logic [2:0] FORM_MEMORY  = 3'd1;
    localparam logic [2:0] FORM_IMM     = 3'd2;
    localparam logic [2:0] FORM_DIRECT  = 3'd3;
    localparam logic [2:0] FORM_UNKNOWN = 3'd4;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_MODRM,
        PH_DISP_LO,
        PH_DISP_HI,
        PH_IMM_LO,
        PH_IMM_HI
    } phase_t;

    // Raw bytes of one completed instruction, as the front end saw them.
    typedef struct packed {
        logic [2:0] form;
        logic [7:0] opcode;
        logic [7:0] modrm;
        logic [7:0] lo;
        logic [7:0] hi;
    } token_t;

    // One formatted result record.
    typedef struct packed {
        logic [2:0]  form;
        logic        memory_is_destination;
        logic        wide;
        logic [3:0]  dest_register;
        logic [3:0]  src_register;
        logic [2:0]  address_form;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [7:0]  bad_opcode;
    } record_t;

endpackage

`default_nettype wire

/* design/xmd_front.sv */
// Front end: byte-by-byte instruction parser that emits raw instruction tokens.
`default_nettype none

`include "x86_16_mov_decoder_assert.svh"

module xmd_front
    import xmd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       queue_ready,
    output logic            tok_valid,
    output token_t          tok
);

    phase_t     phase_reg, phase_next;
    logic [7:0] opcode_reg, opcode_next;
    logic [7:0] modrm_reg, modrm_next;
    logic [7:0] low_reg, low_next;
    logic       xfer;
    logic       done;

    assign in_ready = queue_ready;
    assign xfer     = in_valid && in_ready;
    assign tok_valid = xfer && done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_OPCODE;
            opcode_reg <= 8'h00;
            modrm_reg  <= 8'h00;
            low_reg    <= 8'h00;
        end else begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            low_reg    <= low_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        low_next    = low_reg;
        done        = 1'b0;
        tok.form    = FORM_UNKNOWN;
        tok.opcode  = opcode_reg;
        tok.modrm   = modrm_reg;
        tok.lo      = in_byte;
        tok.hi      = in_byte;
        case (phase_reg)
            PH_MODRM: begin
                modrm_next = in_byte;
                tok.modrm  = in_byte;
                if (in_byte[7:6] == MOD_REG) begin
                    done       = 1'b1;
                    tok.form   = FORM_REG_REG;
                    phase_next = PH_OPCODE;
                end else if (in_byte[7:6] == MOD_NO_DISP && in_byte[2:0] != RM_DIRECT) begin
                    done       = 1'b1;
                    tok.form   = FORM_MEMORY;
                    phase_next = PH_OPCODE;
                end else begin
                    phase_next = PH_DISP_LO;
                end
            end
            PH_DISP_LO: begin
                if (modrm_reg[7:6] == MOD_DISP8) begin
                    done       = 1'b1;
                    tok.form   = FORM_MEMORY;
                    phase_next = PH_OPCODE;
                end else begin
                    low_next   = in_byte;
                    phase_next = PH_DISP_HI;
                end
            end
            PH_DISP_HI: begin
                done       = 1'b1;
                tok.form   = (modrm_reg[7:6] == MOD_NO_DISP) ? FORM_DIRECT : FORM_MEMORY;
                tok.lo     = low_reg;
                phase_next = PH_OPCODE;
            end
            PH_IMM_LO: begin
                if (opcode_reg[3]) begin
                    low_next   = in_byte;
                    phase_next = PH_IMM_HI;
                end else begin
                    done       = 1'b1;
                    tok.form   = FORM_IMM;
                    phase_next = PH_OPCODE;
                end
            end
            PH_IMM_HI: begin
                done       = 1'b1;
                tok.form   = FORM_IMM;
                tok.lo     = low_reg;
                phase_next = PH_OPCODE;
            end
            default: begin
                if (in_byte[7:2] == MOV_RM_OP) begin
                    opcode_next = in_byte;
                    phase_next  = PH_MODRM;
                end else if (in_byte[7:4] == MOV_IMM_OP) begin
                    opcode_next = in_byte;
                    phase_next  = PH_IMM_LO;
                end else begin
                    done       = 1'b1;
                    tok.form   = FORM_UNKNOWN;
                    tok.opcode = in_byte;
                    phase_next = PH_OPCODE;
                end
            end
        endcase
        // hold all state when no byte transfers
        if (!xfer) begin
            phase_next  = phase_reg;
            opcode_next = opcode_reg;
            modrm_next  = modrm_reg;
            low_next    = low_reg;
        end
    end

    `XMD_ASSERT_NEXT(a_done_returns_to_opcode, tok_valid, phase_reg == PH_OPCODE,
        "front: phase did not return to opcode after a completed instruction")
    `XMD_ASSERT_NOW(a_disp_hi_mod, phase_reg == PH_DISP_HI,
        modrm_reg[7:6] == MOD_NO_DISP || modrm_reg[7:6] == MOD_DISP16,
        "front: high displacement byte expected with wrong mod")
    `XMD_ASSERT_NOW(a_imm_hi_wide, phase_reg == PH_IMM_HI, opcode_reg[3],
        "front: high immediate byte expected for a byte-wide move")
    `XMD_ASSERT_NOW(a_token_needs_space, tok_valid, queue_ready,
        "front: token pushed while the queue is full")

endmodule

`default_nettype wire

/* design/xmd_queue.sv */
// Short token queue between the parser and the record formatter.
`default_nettype none

`include "x86_16_mov_decoder_assert.svh"

module xmd_queue
    import xmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = XMD_QUEUE_DEPTH
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire token_t push_tok,
    output logic        push_ready,
    output logic        pop_valid,
    input  wire logic   pop,
    output token_t      pop_tok
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    `XMD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH),
        "queue: occupancy above depth")
    `XMD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1,
        "queue: push alone did not raise occupancy")
    `XMD_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1,
        "queue: pop alone did not lower occupancy")
    `XMD_ASSERT_NOW(a_ptrs_match, count_reg == '0 || count_reg == CW'(QUEUE_DEPTH),
        wr_ptr_reg == rd_ptr_reg, "queue: pointers disagree with empty or full occupancy")

endmodule

`default_nettype wire

/* design/xmd_back.sv */
// Back end: formats queued tokens into result records behind an output register.
`default_nettype none

module xmd_back
    import xmd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   tok_valid,
    output logic        tok_pop,
    input  wire token_t tok,
    output logic        out_valid,
    input  wire logic   out_ready,
    output record_t     out_rec
);

    logic       valid_reg, valid_next;
    record_t    rec_reg, rec_next;
    logic       d, w;
    logic [2:0] reg_f, rm_f;
    logic [3:0] regcode;
    logic [15:0] disp_word;

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;
    assign tok_pop   = tok_valid && (!valid_reg || out_ready);

    assign d         = tok.opcode[1];
    assign w         = tok.opcode[0];
    assign reg_f     = tok.modrm[5:3];
    assign rm_f      = tok.modrm[2:0];
    assign regcode   = {w, reg_f};
    assign disp_word = {tok.hi, tok.lo};

    always_comb begin
        rec_next = '0;
        rec_next.form = tok.form;
        case (tok.form)
            FORM_REG_REG: begin
                rec_next.wide          = w;
                rec_next.dest_register = {w, d ? reg_f : rm_f};
                rec_next.src_register  = {w, d ? rm_f : reg_f};
            end
            FORM_MEMORY, FORM_DIRECT: begin
                rec_next.wide                  = w;
                rec_next.memory_is_destination = !d;
                rec_next.dest_register         = d ? regcode : 4'h0;
                rec_next.src_register          = d ? 4'h0 : regcode;
                if (tok.form == FORM_DIRECT) begin
                    rec_next.displacement = disp_word;
                end else begin
                    rec_next.address_form = rm_f;
                    case (tok.modrm[7:6])
                        MOD_NO_DISP: rec_next.displacement = 16'h0000;
                        MOD_DISP8:   rec_next.displacement = {{8{tok.lo[7]}}, tok.lo};
                        default:     rec_next.displacement = disp_word;
                    endcase
                end
            end
            FORM_IMM: begin
                rec_next.wide          = tok.opcode[3];
                rec_next.dest_register = tok.opcode[3:0];
                rec_next.immediate     = tok.opcode[3] ? disp_word : {8'h00, tok.lo};
            end
            default: begin
                rec_next.bad_opcode = tok.opcode;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (tok_pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // advance the record register only on a pop
    always_ff @(posedge aclk) begin
        if (tok_pop) begin
            rec_reg <= rec_next;
        end
    end

endmodule

`default_nettype wire

/* design/x86_16_mov_decoder.sv */
// Top level of the 8086 MOV decoder: parser, token queue and record formatter.
//
// Input channel s_*: one code byte per transfer (s_valid, s_ready, s_code_byte).
// Output channel m_*: one decoded record per transfer (m_valid, m_ready, fields).
// Recognized are MOV r/m to/from register (100010dw, mod-reg-r/m, optional
// displacement) and MOV immediate to register (1011wreg, one or two data bytes).
// Any other opcode byte yields a record of form unknown for that byte alone.
// Throughput: one code byte per cycle, sustained, while m_ready stays high;
// the parser updates its phase and captures one byte field per byte.
// After the transfer of its last byte, the record of an instruction passes
// through the token queue and then the output register before it is valid
// on m_*.
// When m_ready is low, up to QUEUE_DEPTH completed instructions wait in the
// queue and one in the output register; s_ready drops only when the queue is
// full. Bytes that complete no instruction still need a free queue slot.
// Reset (aresetn low, synchronous) empties the queue and output register and
// returns the parser to expecting an opcode byte.
`default_nettype none

module x86_16_mov_decoder
    import xmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = XMD_QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_code_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_form,
    output logic                   m_memory_is_destination,
    output logic                   m_wide,
    output logic [3:0]             m_dest_register,
    output logic [3:0]             m_src_register,
    output logic [2:0]             m_address_form,
    output logic signed [15:0]     m_displacement,
    output logic [15:0]            m_immediate,
    output logic [7:0]             m_bad_opcode
);

    logic    push, push_ready, pop_valid, pop;
    token_t  push_tok, pop_tok;
    record_t rec;

    xmd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_byte     (s_code_byte),
        .queue_ready (push_ready),
        .tok_valid   (push),
        .tok         (push_tok)
    );

    xmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_tok   (push_tok),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_tok    (pop_tok)
    );

    xmd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (pop_valid),
        .tok_pop   (pop),
        .tok       (pop_tok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (rec)
    );

    assign m_form                  = rec.form;
    assign m_memory_is_destination = rec.memory_is_destination;
    assign m_wide                  = rec.wide;
    assign m_dest_register         = rec.dest_register;
    assign m_src_register          = rec.src_register;
    assign m_address_form          = rec.address_form;
    assign m_displacement          = $signed(rec.displacement);
    assign m_immediate             = rec.immediate;
    assign m_bad_opcode            = rec.bad_opcode;

endmodule

`default_nettype wire
